// ----- hw/rtl/fbrc_pkg.sv -----
package fbrc_pkg;

    // Field widths of the items.
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_W     = 24;
    localparam int RATIO_W     = 32;
    localparam int FRAC_W      = 16;

    // Window lengths and the products that scale the two sums.
    localparam int LEN_W   = 6;
    localparam int LL_W    = 2 * LEN_W;
    localparam int PLAIN_W = SAMPLE_BITS + LEN_W;
    localparam int WSUM_W  = SAMPLE_BITS + 2 * LEN_W - 1;
    localparam int PROD_W  = WSUM_W + LL_W;

    // Restoring divider: one quotient bit per step.
    localparam int DIV_STEPS = RATIO_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Ratio constants in Q16.16.
    localparam logic [RATIO_W-1:0] Q_ONE  = RATIO_W'(32'h0001_0000);
    localparam logic [RATIO_W-1:0] Q_ZERO = '0;
    localparam logic [RATIO_W-1:0] Q_MAX  = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_LEN  = 2'd0,
        CFG_BACK_LEN   = 2'd1,
        CFG_RATIO_MODE = 2'd2
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] FRONT_LEN_RST = LEN_W'(8);
    localparam logic [LEN_W-1:0] BACK_LEN_RST  = LEN_W'(16);

    // Ratio mode codes.
    localparam logic MODE_TRIANGLE = 1'b0;
    localparam logic MODE_BOX      = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in_item;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [COUNT_W-1:0] point_index;
        logic               computed;
        logic               last_point;
    } t_out_item;

endpackage

// ----- hw/rtl/front_back_ratio_curve.sv -----
// Sequence: a point that runs the 32-step divider first walks its F front and B back
// history entries on one memory read port, then sums, scales, checks and divides; a
// zero-sum or saturated point skips the divider, and a fill point skips all of these.
// No new sample is taken until the point is presented, which an output stall can hold;
// a sample completing no point is taken every cycle; a final sample flushes tail fills.
// Synchronous active-low reset clears control state and restores F=8, B=16, triangle mode.
module front_back_ratio_curve #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  fbrc_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output fbrc_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [fbrc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fbrc_pkg::LEN_W-1:0]            i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = ((AW > fbrc_pkg::LEN_W) ? AW : fbrc_pkg::LEN_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] ADDR_LAST = AW'(HISTORY_DEPTH - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FRONT = 11'b000_0000_0010,
        S_BACK  = 11'b000_0000_0100,
        S_FIN   = 11'b000_0000_1000,
        S_SUM   = 11'b000_0001_0000,
        S_MULN  = 11'b000_0010_0000,
        S_MULD  = 11'b000_0100_0000,
        S_CHECK = 11'b000_1000_0000,
        S_DIV   = 11'b001_0000_0000,
        S_EMIT  = 11'b010_0000_0000,
        S_FILL  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration and record position.
    logic [fbrc_pkg::LEN_W-1:0]   r_front_len, r_back_len;
    logic                         r_ratio_mode;
    logic [fbrc_pkg::COUNT_W-1:0] r_count;
    logic [AW-1:0]                r_ptr;

    // Per-item work registers.
    logic [fbrc_pkg::COUNT_W-1:0] r_m, r_n, r_p;
    logic                         r_last;
    logic [fbrc_pkg::LL_W-1:0]    r_ff, r_bb;
    logic [AW-1:0]                r_addr, r_bstart;
    logic [fbrc_pkg::LEN_W-1:0]   r_cnt;
    logic [fbrc_pkg::PROD_W-1:0]  r_num, r_den, r_rem;
    logic [fbrc_pkg::RATIO_W-1:0] r_dvd, r_res;
    logic                         r_comp;
    logic [fbrc_pkg::DCNT_W-1:0]  r_div_cnt;

    // History memory and its read pipeline.
    logic [fbrc_pkg::SAMPLE_BITS-1:0] r_hist [HISTORY_DEPTH];
    logic [fbrc_pkg::SAMPLE_BITS-1:0] r_rd;
    logic                             r_rd_vld, r_rd_back;

    // Window accumulators: plain sums and sums of running plain sums.
    logic [fbrc_pkg::PLAIN_W-1:0] r_fp, r_bp;
    logic [fbrc_pkg::WSUM_W-1:0]  r_fw, r_bw;

    // Output register.
    logic                r_out_valid;
    fbrc_pkg::t_out_item r_out_data;

    logic                             in_acc, out_free, out_load, rd_en;
    logic [fbrc_pkg::LEN_W-1:0]       f_eff, b_eff;
    logic [fbrc_pkg::SAMPLE_BITS-1:0] mag;
    logic                             has_pt, fits, do_calc;
    logic [fbrc_pkg::COUNT_W-1:0]     n_calc;
    logic [CW-1:0]                    ptr_c, f_c, f1_c, fstart_c, bstart_c;
    logic [fbrc_pkg::RATIO_W-1:0]     fill_val;
    logic [fbrc_pkg::WSUM_W-1:0]      fs_sel, bs_sel, mul_a;
    logic [fbrc_pkg::LL_W-1:0]        mul_b;
    logic [fbrc_pkg::PROD_W-1:0]      mul_p;
    logic                             is_zero, is_sat;
    logic [fbrc_pkg::PROD_W:0]        div_t;
    logic                             div_ge;
    logic [AW-1:0]                    addr_inc, addr_dec;

    // Handshake and effective window lengths.
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign out_load    = out_free && ((r_state == S_EMIT) || (r_state == S_FILL));
    assign rd_en       = (r_state == S_FRONT) || (r_state == S_BACK);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign f_eff = (r_front_len == '0) ? fbrc_pkg::LEN_W'(1) : r_front_len;
    assign b_eff = (r_back_len == '0) ? fbrc_pkg::LEN_W'(1) : r_back_len;
    assign fill_val = (r_ratio_mode == fbrc_pkg::MODE_BOX) ? fbrc_pkg::Q_ZERO
                                                             : fbrc_pkg::Q_ONE;

    // Magnitude of the incoming sample.
    assign mag = i_in_data.sample[fbrc_pkg::SAMPLE_BITS-1]
               ? fbrc_pkg::SAMPLE_BITS'(~$unsigned(i_in_data.sample)
                                        + fbrc_pkg::SAMPLE_BITS'(1))
               : $unsigned(i_in_data.sample);

    // Which point this sample completes and whether its windows fit.
    assign has_pt  = r_count >= fbrc_pkg::COUNT_W'(f_eff - fbrc_pkg::LEN_W'(1));
    assign n_calc  = r_count - fbrc_pkg::COUNT_W'(f_eff) + fbrc_pkg::COUNT_W'(1);
    assign fits    = (CW'(f_eff) + CW'(b_eff)) <= DEPTH_C;
    assign do_calc = has_pt && fits && (n_calc >= fbrc_pkg::COUNT_W'(b_eff));

    // Start slots: the front walk climbs from the oldest front sample to the newest,
    // the back walk descends from the newest back sample to the oldest.
    assign ptr_c    = CW'(r_ptr);
    assign f_c      = CW'(f_eff);
    assign f1_c     = CW'(f_eff - fbrc_pkg::LEN_W'(1));
    assign fstart_c = (ptr_c >= f1_c) ? (ptr_c - f1_c) : (ptr_c + DEPTH_C - f1_c);
    assign bstart_c = (ptr_c >= f_c) ? (ptr_c - f_c) : (ptr_c + DEPTH_C - f_c);

    assign addr_inc = (r_addr == ADDR_LAST) ? '0 : r_addr + AW'(1);
    assign addr_dec = (r_addr == '0) ? ADDR_LAST : r_addr - AW'(1);

    // Shared multiplier: scales the front sum, then the back sum.
    assign fs_sel = (r_ratio_mode == fbrc_pkg::MODE_BOX) ? fbrc_pkg::WSUM_W'(r_fp) : r_fw;
    assign bs_sel = (r_ratio_mode == fbrc_pkg::MODE_BOX) ? fbrc_pkg::WSUM_W'(r_bp) : r_bw;
    assign mul_a  = (r_state == S_MULN) ? fs_sel : bs_sel;
    assign mul_b  = (r_state == S_MULN) ? r_bb : r_ff;
    assign mul_p  = fbrc_pkg::PROD_W'(mul_a) * fbrc_pkg::PROD_W'(mul_b);

    // Special cases of the ratio and one restoring division step.
    assign is_zero = (r_num == '0) || (r_den == '0);
    assign is_sat  = {{fbrc_pkg::FRAC_W{1'b0}}, r_num} >= {r_den, {fbrc_pkg::FRAC_W{1'b0}}};
    assign div_t   = {r_rem, r_dvd[fbrc_pkg::RATIO_W-1]};
    assign div_ge  = div_t >= {1'b0, r_den};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (do_calc) begin
                        n_state = S_FRONT;
                    end else if (has_pt) begin
                        n_state = S_EMIT;
                    end else if (i_in_data.last_sample) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FRONT: begin
                if (r_cnt == '0) begin
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_SUM;
            S_SUM:  n_state = S_MULN;
            S_MULN: n_state = S_MULD;
            S_MULD: n_state = S_CHECK;
            S_CHECK: begin
                n_state = (is_zero || is_sat) ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_last && (r_n != r_m)) ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                if (out_free && (r_p == r_m)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and record position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front_len  <= fbrc_pkg::FRONT_LEN_RST;
            r_back_len   <= fbrc_pkg::BACK_LEN_RST;
            r_ratio_mode <= fbrc_pkg::MODE_TRIANGLE;
            r_count      <= '0;
            r_ptr        <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fbrc_pkg::CFG_FRONT_LEN:  r_front_len  <= i_cfg_data;
                    fbrc_pkg::CFG_BACK_LEN:   r_back_len   <= i_cfg_data;
                    fbrc_pkg::CFG_RATIO_MODE: r_ratio_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (i_in_data.last_sample) begin
                    r_count <= '0;
                    r_ptr   <= '0;
                end else begin
                    r_count <= r_count + fbrc_pkg::COUNT_W'(1);
                    r_ptr   <= (r_ptr == ADDR_LAST) ? '0 : r_ptr + AW'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // History memory: one write at acceptance, one registered read per walk step.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hist[r_ptr] <= mag;
        end
        if (rd_en) begin
            r_rd      <= r_hist[r_addr];
            r_rd_back <= (r_state == S_BACK);
        end
    end

    // Accumulators: each weighted sum adds the running plain sum once per sample,
    // which gives the triangle weights, then adds the final plain sum once more.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fp <= '0;
            r_fw <= '0;
            r_bp <= '0;
            r_bw <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_back) begin
                r_bp <= r_bp + fbrc_pkg::PLAIN_W'(r_rd);
                r_bw <= r_bw + fbrc_pkg::WSUM_W'(r_bp);
            end else begin
                r_fp <= r_fp + fbrc_pkg::PLAIN_W'(r_rd);
                r_fw <= r_fw + fbrc_pkg::WSUM_W'(r_fp);
            end
        end else if (r_state == S_SUM) begin
            r_fw <= r_fw + fbrc_pkg::WSUM_W'(r_fp);
            r_bw <= r_bw + fbrc_pkg::WSUM_W'(r_bp);
        end
    end

    // Per-item datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_m      <= r_count;
                    r_n      <= n_calc;
                    r_p      <= '0;
                    r_last   <= i_in_data.last_sample;
                    r_ff     <= fbrc_pkg::LL_W'(f_eff)
                              * (fbrc_pkg::LL_W'(f_eff) + fbrc_pkg::LL_W'(1));
                    r_bb     <= fbrc_pkg::LL_W'(b_eff)
                              * (fbrc_pkg::LL_W'(b_eff) + fbrc_pkg::LL_W'(1));
                    r_addr   <= fstart_c[AW-1:0];
                    r_bstart <= bstart_c[AW-1:0];
                    r_cnt    <= f_eff - fbrc_pkg::LEN_W'(1);
                    r_res    <= fill_val;
                    r_comp   <= 1'b0;
                end
            end
            S_FRONT: begin
                if (r_cnt == '0) begin
                    r_addr <= r_bstart;
                    r_cnt  <= b_eff - fbrc_pkg::LEN_W'(1);
                end else begin
                    r_addr <= addr_inc;
                    r_cnt  <= r_cnt - fbrc_pkg::LEN_W'(1);
                end
            end
            S_BACK: begin
                r_addr <= addr_dec;
                r_cnt  <= r_cnt - fbrc_pkg::LEN_W'(1);
            end
            S_MULN: r_num <= mul_p;
            S_MULD: r_den <= mul_p;
            S_CHECK: begin
                if (is_zero) begin
                    r_res  <= fill_val;
                    r_comp <= 1'b0;
                end else if (is_sat) begin
                    r_res  <= fbrc_pkg::Q_MAX;
                    r_comp <= 1'b1;
                end else begin
                    r_rem     <= fbrc_pkg::PROD_W'(r_num >> fbrc_pkg::FRAC_W);
                    r_dvd     <= {r_num[fbrc_pkg::FRAC_W-1:0], {fbrc_pkg::FRAC_W{1'b0}}};
                    r_res     <= '0;
                    r_comp    <= 1'b1;
                    r_div_cnt <= fbrc_pkg::DCNT_W'(fbrc_pkg::DIV_STEPS - 1);
                end
            end
            S_DIV: begin
                if (div_ge) begin
                    r_rem <= fbrc_pkg::PROD_W'(div_t - {1'b0, r_den});
                end else begin
                    r_rem <= div_t[fbrc_pkg::PROD_W-1:0];
                end
                r_res     <= {r_res[fbrc_pkg::RATIO_W-2:0], div_ge};
                r_dvd     <= {r_dvd[fbrc_pkg::RATIO_W-2:0], 1'b0};
                r_div_cnt <= r_div_cnt - fbrc_pkg::DCNT_W'(1);
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_data.ratio       <= r_res;
                    r_out_data.point_index <= r_n;
                    r_out_data.computed    <= r_comp;
                    r_out_data.last_point  <= r_last && (r_n == r_m);
                    r_p                    <= r_n + fbrc_pkg::COUNT_W'(1);
                end
            end
            S_FILL: begin
                if (out_free) begin
                    r_out_data.ratio       <= fill_val;
                    r_out_data.point_index <= r_p;
                    r_out_data.computed    <= 1'b0;
                    r_out_data.last_point  <= (r_p == r_m);
                    r_p                    <= r_p + fbrc_pkg::COUNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // The divider remainder stays below the divisor at every step.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // A final sample restarts the record position.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_sample) |=> ((r_count == '0) && (r_ptr == '0)))
        else $error("record position not cleared after final sample");

    // The history pointer stays inside the memory.
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= ADDR_LAST)
        else $error("history pointer out of range");

    // Tail fill points never run past the final sample index.
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_p <= r_m))
        else $error("tail fill point beyond final sample");

endmodule

// ----- tb/front_back_ratio_curve_tb.sv -----
`timescale 1ns / 1ps

module front_back_ratio_curve_tb;

    localparam int HISTORY_DEPTH  = 128;
    localparam int SLOT_W         = $clog2(HISTORY_DEPTH);
    localparam int MAX_POINTS     = 64;
    localparam int MAX_GAP        = 4;
    localparam int SETTLE_CYCLES  = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 270;
    localparam int PRINT_LIMIT    = 30;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    fbrc_pkg::t_in_item             in_data   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [fbrc_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [fbrc_pkg::LEN_W-1:0]     cfg_data  = '0;
    logic                           in_stall;
    logic                           out_valid;
    fbrc_pkg::t_out_item            out_data;

    // Window settings as the block should hold them.
    logic [fbrc_pkg::LEN_W-1:0] cfg_front = fbrc_pkg::FRONT_LEN_RST;
    logic [fbrc_pkg::LEN_W-1:0] cfg_back  = fbrc_pkg::BACK_LEN_RST;
    logic                       cfg_mode  = fbrc_pkg::MODE_TRIANGLE;

    // Magnitude history and record position of the ratio predictor.
    logic [fbrc_pkg::SAMPLE_BITS-1:0] mag_hist [HISTORY_DEPTH];
    int unsigned                      rec_index = 0;
    int unsigned                      hist_slot = 0;

    fbrc_pkg::t_in_item  pending_samples [$];
    fbrc_pkg::t_out_item expected_points [$];

    // Idle control shared between the sequence and the two channel processes.
    bit drv_idle_on = 1'b1;
    bit mon_idle_on = 1'b1;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;

    // Run statistics.
    int fail_count       = 0;
    int samples_sent     = 0;
    int records_done     = 0;
    int points_checked   = 0;
    int points_computed  = 0;
    int points_saturated = 0;
    int settings_used    = 0;
    int queued_random    = 0;

    front_back_ratio_curve #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 20 ns clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    // Unsigned Q16.16 quotient, truncated, saturating when the integer part overflows.
    function automatic logic [fbrc_pkg::RATIO_W-1:0] q16_quotient(input logic [63:0] num,
                                                                  input logic [63:0] den);
        logic [63:0]                  whole;
        logic [63:0]                  rem;
        logic [fbrc_pkg::RATIO_W-1:0] q;
        int                           i;
        whole = num / den;
        rem   = num % den;
        if (whole >= 64'd65536) begin
            return fbrc_pkg::Q_MAX;
        end
        q = whole[fbrc_pkg::RATIO_W-1:0];
        for (i = 0; i < fbrc_pkg::FRAC_W; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic fbrc_pkg::t_out_item make_point(
        input logic [fbrc_pkg::RATIO_W-1:0] ratio, input int unsigned idx,
        input logic comp, input logic lastp);
        fbrc_pkg::t_out_item pt;
        pt.ratio       = ratio;
        pt.point_index = fbrc_pkg::COUNT_W'(idx);
        pt.computed    = comp;
        pt.last_point  = lastp;
        return pt;
    endfunction

    // Works out the ratio points that one accepted sample produces.
    task automatic predict_points(input fbrc_pkg::t_in_item item);
        int unsigned                      f, b, m, n, p, k, first_tail, produced;
        logic [fbrc_pkg::SAMPLE_BITS-1:0] raw, mag;
        logic [63:0]                      front_w, front_p, back_w, back_p;
        logic [63:0]                      front_s, back_s, a;
        logic [fbrc_pkg::RATIO_W-1:0]     fill, ratio;
        logic                             comp;
        f    = (cfg_front == 0) ? 1 : cfg_front;
        b    = (cfg_back == 0) ? 1 : cfg_back;
        fill = (cfg_mode == fbrc_pkg::MODE_BOX) ? fbrc_pkg::Q_ZERO : fbrc_pkg::Q_ONE;
        raw  = item.sample;
        mag  = raw[fbrc_pkg::SAMPLE_BITS-1] ? ((~raw) + 1'b1) : raw;
        m    = rec_index;
        mag_hist[SLOT_W'(hist_slot)] = mag;
        produced = 0;

        // The point whose front window has just been completed.
        if (m >= f - 1) begin
            n     = m - (f - 1);
            ratio = fill;
            comp  = 1'b0;
            if (n >= b && f + b <= HISTORY_DEPTH) begin
                front_w = '0;
                front_p = '0;
                back_w  = '0;
                back_p  = '0;
                for (k = 0; k < f; k++) begin
                    a = mag_hist[SLOT_W'((hist_slot + HISTORY_DEPTH - (f - 1 - k))
                                         % HISTORY_DEPTH)];
                    front_w += 64'(f - k) * a;
                    front_p += a;
                end
                for (k = 1; k <= b; k++) begin
                    a = mag_hist[SLOT_W'((hist_slot + HISTORY_DEPTH - (f - 1 + k))
                                         % HISTORY_DEPTH)];
                    back_w += 64'(b - k + 1) * a;
                    back_p += a;
                end
                front_s = (cfg_mode == fbrc_pkg::MODE_BOX) ? front_p : front_w;
                back_s  = (cfg_mode == fbrc_pkg::MODE_BOX) ? back_p : back_w;
                if (front_s != 0 && back_s != 0) begin
                    ratio = q16_quotient(front_s * (64'(b) * 64'(b + 1)),
                                         back_s * (64'(f) * 64'(f + 1)));
                    comp  = 1'b1;
                end
            end
            expected_points.push_back(make_point(ratio, n, comp, item.last_sample && n == m));
            produced++;
            first_tail = m - f + 2;
        end else begin
            first_tail = 0;
        end

        // The final sample flushes the points that can no longer be completed.
        if (item.last_sample) begin
            for (p = first_tail; p <= m && produced < MAX_POINTS; p++) begin
                expected_points.push_back(make_point(fill, p, 1'b0, p == m));
                produced++;
            end
            rec_index = 0;
            hist_slot = 0;
            records_done++;
        end else begin
            rec_index = (m + 1) % (1 << fbrc_pkg::COUNT_W);
            hist_slot = (hist_slot + 1) % HISTORY_DEPTH;
        end
    endtask

    // Input driver: feeds queued samples with a random gap between them when gaps are enabled.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_points(in_data);
                samples_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    in_data  <= pending_samples.pop_front();
                    in_valid <= 1'b1;
                    gap_left = drv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted point and draws the next stall.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && !out_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point %0d ratio %h",
                                              out_data.point_index, out_data.ratio));
                end else begin
                    fbrc_pkg::t_out_item want;
                    want = expected_points.pop_front();
                    if (out_data.ratio !== want.ratio)
                        report_mismatch($sformatf("point %0d ratio %h, expected %h",
                                                  want.point_index, out_data.ratio,
                                                  want.ratio));
                    if (out_data.point_index !== want.point_index)
                        report_mismatch($sformatf("point_index %0d, expected %0d",
                                                  out_data.point_index, want.point_index));
                    if (out_data.computed !== want.computed)
                        report_mismatch($sformatf("point %0d computed %b, expected %b",
                                                  want.point_index, out_data.computed,
                                                  want.computed));
                    if (out_data.last_point !== want.last_point)
                        report_mismatch($sformatf("point %0d last_point %b, expected %b",
                                                  want.point_index, out_data.last_point,
                                                  want.last_point));
                    if (want.computed) points_computed++;
                    if (want.computed && want.ratio == fbrc_pkg::Q_MAX) points_saturated++;
                end
                points_checked++;
                stall_left = mon_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end else if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles, %0d points outstanding",
                         WATCHDOG_LIMIT, expected_points.size());
                $display("** front_back_ratio_curve: FAILED **");
                $finish;
            end
        end
    end

    // Waits until every sample is in and every point is out, then lets the block settle.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (pending_samples.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input fbrc_pkg::t_cfg_idx idx,
                             input logic [fbrc_pkg::LEN_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            fbrc_pkg::CFG_FRONT_LEN: cfg_front = value;
            fbrc_pkg::CFG_BACK_LEN:  cfg_back  = value;
            default:                 cfg_mode  = value[0];
        endcase
    endtask

    task automatic apply_setting(input int f, input int b, input logic mode);
        wait_idle();
        write_reg(fbrc_pkg::CFG_FRONT_LEN, fbrc_pkg::LEN_W'(f));
        write_reg(fbrc_pkg::CFG_BACK_LEN, fbrc_pkg::LEN_W'(b));
        write_reg(fbrc_pkg::CFG_RATIO_MODE, fbrc_pkg::LEN_W'(mode));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic push_sample(input logic [fbrc_pkg::SAMPLE_BITS-1:0] value,
                               input logic last);
        fbrc_pkg::t_in_item item;
        item.sample      = value;
        item.last_sample = last;
        pending_samples.push_back(item);
    endtask

    function automatic logic [fbrc_pkg::SAMPLE_BITS-1:0] rand_sample(input int zero_pct);
        int unsigned pick;
        if ($urandom_range(0, 99) < zero_pct) begin
            return '0;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return fbrc_pkg::SAMPLE_BITS'($urandom_range(0, 30))
                          - fbrc_pkg::SAMPLE_BITS'(15);
            default: return fbrc_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // Queues a run of random samples; the final one closes the record when asked.
    task automatic push_record(input int len, input bit ends, input int zero_pct);
        int i;
        for (i = 0; i < len; i++) begin
            push_sample(rand_sample(zero_pct), ends && i == len - 1);
            queued_random++;
        end
    endtask

    // Test sequence.
    initial begin
        int f, b, fe, be, len, zero_pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short record at the reset setting: all points flush as fill.
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h800000, 1'b0);
        push_sample(24'h000000, 1'b1);

        // Single-sample windows: saturation, tiny ratio, zero front and zero back.
        apply_setting(1, 1, fbrc_pkg::MODE_TRIANGLE);
        push_sample(24'h000005, 1'b0);
        push_sample(24'h7FFFFF, 1'b0);
        push_sample(24'h000001, 1'b0);
        push_sample(24'h800000, 1'b0);
        push_sample(24'h000000, 1'b0);
        push_sample(24'h000000, 1'b0);
        push_sample(24'hFFFFFF, 1'b0);
        push_sample(24'h000007, 1'b1);

        // Zero lengths act as one, box mode fills with zero.
        apply_setting(0, 0, fbrc_pkg::MODE_BOX);
        push_sample(24'h000003, 1'b0);
        push_sample(24'hFFFFFA, 1'b0);
        push_sample(24'h000000, 1'b0);
        push_sample(24'h000009, 1'b1);

        // Box ratio followed by a one-point tail flush.
        apply_setting(2, 3, fbrc_pkg::MODE_BOX);
        push_sample(24'h00000A, 1'b0);
        push_sample(24'h000014, 1'b0);
        push_sample(24'h00001E, 1'b0);
        push_sample(24'h000028, 1'b0);
        push_sample(24'h000032, 1'b0);
        push_sample(24'h00003C, 1'b0);
        push_sample(24'h7FFFFF, 1'b1);

        // Receiver holds off while the sender streams without gaps, so the block backs up.
        apply_setting(3, 4, fbrc_pkg::MODE_TRIANGLE);
        drv_idle_on = 1'b0;
        mon_idle_on = 1'b1;
        hold_req++;
        push_record(40, 1'b1, 0);
        // Sender stops in the middle of a record until every point has come out.
        push_record(10, 1'b0, 0);
        wait_idle();
        drv_idle_on = 1'b1;
        push_record(10, 1'b1, 0);

        // Longest front window: the final sample flushes the longest tail.
        apply_setting(63, 1, fbrc_pkg::MODE_TRIANGLE);
        push_record(66, 1'b1, 0);
        // Longest back window in box mode.
        apply_setting(1, 63, fbrc_pkg::MODE_BOX);
        push_record(66, 1'b1, 0);
        // Both windows at their longest: a short record gives fill only.
        apply_setting(63, 63, fbrc_pkg::MODE_BOX);
        push_record(12, 1'b1, 0);
        // Window lengths and mode change in the middle of a record.
        apply_setting(4, 5, fbrc_pkg::MODE_TRIANGLE);
        push_record(16, 1'b0, 10);
        apply_setting(6, 2, fbrc_pkg::MODE_BOX);
        push_record(14, 1'b1, 10);

        // Random settings with mostly complete records and some short ones.
        while (queued_random < RANDOM_ITEMS) begin
            f = $urandom_range(0, 7);
            b = $urandom_range(0, 10);
            apply_setting(f, b, 1'($urandom_range(0, 1)));
            drv_idle_on = ($urandom_range(0, 3) != 0);
            mon_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0, 1:    zero_pct = 0;
                2:       zero_pct = 15;
                default: zero_pct = 60;
            endcase
            fe = (f == 0) ? 1 : f;
            be = (b == 0) ? 1 : b;
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(0, 9) < 7) begin
                    len = $urandom_range(fe + be + 1, fe + be + 16);
                end else begin
                    len = $urandom_range(1, fe + be);
                end
                if ($urandom_range(0, 7) == 0) begin
                    push_record(len / 2, 1'b0, zero_pct);
                    wait_idle();
                    push_record(len - len / 2, 1'b1, zero_pct);
                end else begin
                    push_record(len, 1'b1, zero_pct);
                end
            end
        end

        wait_idle();
        $display("Checked %0d ratio points (%0d computed, %0d saturated) from %0d samples",
                 points_checked, points_computed, points_saturated, samples_sent);
        $display("in %0d records over %0d window settings, with random gaps on both sides.",
                 records_done, settings_used);
        if (fail_count == 0) begin
            $display("** front_back_ratio_curve: PASSED **");
        end else begin
            $display("** front_back_ratio_curve: FAILED **");
        end
        $finish;
    end

endmodule
